// File: sv/pidl_pkg.sv
// Shared types and codes for the positional insert/delete list.
package pidl_pkg;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_DELETE = 2'd1;
	localparam logic [1:0] FUNC_DUMP   = 2'd2;
	// Spare code with no operation behind it.
	localparam logic [1:0] FUNC_SPARE  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BEYOND = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_BADPOS = 2'd3;

	// Most results one dump may produce.
	localparam int unsigned MAX_RESULTS = 16;

	// Load selections of one list cell.
	localparam logic [1:0] CELL_HOLD  = 2'd0;
	localparam logic [1:0] CELL_PREV  = 2'd1;
	localparam logic [1:0] CELL_NEXT  = 2'd2;
	localparam logic [1:0] CELL_FRESH = 2'd3;

	typedef struct packed {
		logic [1:0]         func;
		logic [7:0]         position;
		logic signed [31:0] value;
	} pidl_cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               has_element;
		logic signed [31:0] element;
		logic [3:0]         element_index;
		logic [4:0]         free_slots;
		logic               last;
	} pidl_result_t;

	typedef struct packed {
		logic [1:0] sel;
	} pidl_cell_ctrl_t;

endpackage

// File: sv/pidl_cell.sv
// One list cell: holds a single entry and loads from either neighbour or the shared bus.
module pidl_cell (
	input  logic                      clk,
	input  pidl_pkg::pidl_cell_ctrl_t ctrl,
	input  logic signed [31:0]        prev,
	input  logic signed [31:0]        next,
	input  logic signed [31:0]        fresh,
	output logic signed [31:0]        data
);
	import pidl_pkg::*;

	logic signed [31:0] data_q;

	always_ff @(posedge clk) begin
		case (ctrl.sel)
			CELL_PREV:  data_q <= prev;
			CELL_NEXT:  data_q <= next;
			CELL_FRESH: data_q <= fresh;
			default:    data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

// File: sv/positional_insert_delete_list_core.sv
// Top level of the positional insert/delete list: a row of shifting cells and its control.
// On insert and delete every cell from the given position onward loads from its neighbour
// at once (on insert the cell at the position takes the command value), and the single
// result appears on the result port, marked by strobe, in the cycle after the command
// transfer. A dump rotates the list through the row of cells one place per cycle, reading
// the head cell, with busy high until every entry has come round; a dump of an empty
// list never raises busy. Dump results follow one per cycle, registered from the head
// cell, and only the first sixteen entries are reported. Results cannot be held off, so
// the receiver must take each one in the cycle that strobe marks it.
module positional_insert_delete_list_core #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  pidl_pkg::pidl_cmd_t    cmd,
	output logic                   busy,
	output logic                   strobe,
	output pidl_pkg::pidl_result_t result
);
	import pidl_pkg::*;

	localparam int unsigned LW = $clog2(CAPACITY + 1);
	localparam int unsigned CW = $clog2(CAPACITY);

	logic [LW-1:0]      len_q, len_d;
	logic [CW-1:0]      cnt_q, cnt_d;
	logic               busy_q, busy_d;
	logic               strobe_q, strobe_d;
	pidl_result_t       result_q, result_d;
	pidl_cell_ctrl_t    ctrl [CAPACITY];
	logic signed [31:0] cell_data [CAPACITY];
	logic signed [31:0] fresh;
	logic               accept;
	logic [8:0]         pos9, len9, cap9, p0, cnt9, nres;
	logic [1:0]         ins_status, del_status;

	assign accept = start && !busy_q;
	assign pos9   = {1'b0, cmd.position};
	assign len9   = 9'(len_q);
	assign cap9   = 9'(CAPACITY);
	assign p0     = pos9 - 9'd1;
	assign cnt9   = 9'(cnt_q);
	assign nres   = (len9 > 9'(MAX_RESULTS)) ? 9'(MAX_RESULTS) : len9;
	// During a dump the tail cell takes the head entry back, so the list is whole again.
	assign fresh  = busy_q ? cell_data[0] : cmd.value;

	always_comb begin
		if (pos9 > cap9) begin
			ins_status = ST_BEYOND;
		end else if (len9 >= cap9) begin
			ins_status = ST_FULL;
		end else if (pos9 == 9'd0 || pos9 > len9 + 9'd1) begin
			ins_status = ST_BADPOS;
		end else begin
			ins_status = ST_OK;
		end
		del_status = (pos9 == 9'd0 || pos9 > len9) ? ST_BADPOS : ST_OK;
	end

	always_comb begin
		len_d    = len_q;
		cnt_d    = cnt_q;
		busy_d   = busy_q;
		strobe_d = 1'b0;
		result_d = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			ctrl[i].sel = CELL_HOLD;
		end
		if (busy_q) begin
			strobe_d               = cnt9 < 9'(MAX_RESULTS);
			result_d.status        = ST_OK;
			result_d.has_element   = 1'b1;
			result_d.element       = cell_data[0];
			result_d.element_index = 4'(cnt_q);
			result_d.free_slots    = 5'(cap9 - len9);
			result_d.last          = (cnt9 + 9'd1 == nres);
			for (int i = 0; i < CAPACITY; i++) begin
				if (9'(i) + 9'd1 < len9) begin
					ctrl[i].sel = CELL_NEXT;
				end else if (9'(i) + 9'd1 == len9) begin
					ctrl[i].sel = CELL_FRESH;
				end
			end
			if (cnt9 + 9'd1 == len9) begin
				busy_d = 1'b0;
				cnt_d  = '0;
			end else begin
				cnt_d = cnt_q + CW'(1);
			end
		end else if (accept) begin
			strobe_d      = 1'b1;
			result_d.last = 1'b1;
			case (cmd.func)
				FUNC_INSERT: begin
					result_d.status = ins_status;
					if (ins_status == ST_OK) begin
						len_d = len_q + LW'(1);
						for (int i = 0; i < CAPACITY; i++) begin
							if (9'(i) == p0) begin
								ctrl[i].sel = CELL_FRESH;
							end else if (9'(i) > p0) begin
								ctrl[i].sel = CELL_PREV;
							end
						end
					end
				end
				FUNC_DELETE: begin
					result_d.status = del_status;
					if (del_status == ST_OK) begin
						len_d = len_q - LW'(1);
						for (int i = 0; i < CAPACITY; i++) begin
							if (9'(i) >= p0) begin
								ctrl[i].sel = CELL_NEXT;
							end
						end
					end
				end
				FUNC_DUMP: begin
					if (len9 != 9'd0) begin
						strobe_d = 1'b0;
						busy_d   = 1'b1;
						cnt_d    = '0;
					end
				end
				default: begin
					result_d.status = ST_OK;
				end
			endcase
			result_d.free_slots = 5'(cap9 - 9'(len_d));
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [31:0] prev_w, next_w;
		if (g == 0) begin : g_head
			assign prev_w = '0;
		end else begin : g_body
			assign prev_w = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_tail
			assign next_w = '0;
		end else begin : g_link
			assign next_w = cell_data[g+1];
		end
		pidl_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl[g]),
			.prev  (prev_w),
			.next  (next_w),
			.fresh (fresh),
			.data  (cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			cnt_q    <= '0;
			busy_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			busy_q   <= busy_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign busy   = busy_q;
	assign strobe = strobe_q;
	assign result = result_q;

	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		9'(len_q) <= 9'(CAPACITY))
		else $error("list length above capacity");

	a_cnt_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> 9'(cnt_q) < 9'(len_q))
		else $error("dump counter past the end of the list");

	// A list longer than the result limit keeps rotating after its final result.
	a_last_ends_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && result_q.last && 9'(len_q) <= 9'(MAX_RESULTS)) |-> !busy_q)
		else $error("final result shown while still busy");

	a_dump_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && 9'(cnt_q) < 9'(MAX_RESULTS)) |=> strobe_q)
		else $error("dump step produced no result");

	a_len_steady_dump: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> $stable(len_q))
		else $error("list length changed during a dump");

endmodule
